// ===== hw/rtl/bc1_pkg.sv =====
// bc1_pkg: shared types, constants and color helpers for the bc1 block decoder
// used by bc1_front, bc1_queue, bc1_back and bc1_block_decoder
`timescale 1ns / 1ps

package bc1_pkg;

   localparam logic [3:0] LAST_TEXEL_POS = 4'd15;
   localparam logic [10:0] THIRD_RECIP = 11'd683;   // 683 / 2048 ~ 1/3, exact for x <= 765

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   typedef struct packed {
      rgb_type [3:0] palette;
      logic [31:0]   selectors;
   } block_type;

   function automatic rgb_type expand565(input logic [15:0] c);
      rgb_type o;
      o.red   = {c[15:11], c[15:13]};
      o.green = {c[10:5], c[10:9]};
      o.blue  = {c[4:0], c[4:2]};
      return o;
   endfunction

   // (2h + l) / 3 via reciprocal multiply
   function automatic logic [7:0] third_chan(input logic [7:0] h, input logic [7:0] l);
      logic [9:0]  x;
      logic [20:0] prod;
      x    = {1'b0, h, 1'b0} + {2'b00, l};
      prod = {11'd0, x} * {10'd0, THIRD_RECIP};
      return prod[18:11];
   endfunction

   function automatic logic [7:0] half_chan(input logic [7:0] p, input logic [7:0] q);
      logic [8:0] s;
      s = {1'b0, p} + {1'b0, q};
      return s[8:1];
   endfunction

endpackage

// ===== hw/rtl/bc1_front.sv =====
// bc1_front: accepts a compressed block, expands endpoints and builds the palette
// depends on bc1_pkg; feeds bc1_queue
`timescale 1ns / 1ps

module bc1_front import bc1_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_endpoint_a,
   input  logic [15:0] req_endpoint_b,
   input  logic [31:0] req_selector_bits,
   output logic        blk_valid,
   input  logic        blk_ready,
   output block_type   blk_data
);

   logic      valid_ff, valid_in;
   block_type data_ff, data_in;
   rgb_type   col_a, col_b;

   assign req_ready = !valid_ff || blk_ready;

   always_comb begin
      col_a = expand565(req_endpoint_a);
      col_b = expand565(req_endpoint_b);
      data_in.selectors = req_selector_bits;
      data_in.palette[0] = col_a;
      data_in.palette[1] = col_b;
      if (req_endpoint_a > req_endpoint_b) begin
         data_in.palette[2].red   = third_chan(col_a.red, col_b.red);
         data_in.palette[2].green = third_chan(col_a.green, col_b.green);
         data_in.palette[2].blue  = third_chan(col_a.blue, col_b.blue);
         data_in.palette[3].red   = third_chan(col_b.red, col_a.red);
         data_in.palette[3].green = third_chan(col_b.green, col_a.green);
         data_in.palette[3].blue  = third_chan(col_b.blue, col_a.blue);
      end else begin
         data_in.palette[2].red   = half_chan(col_a.red, col_b.red);
         data_in.palette[2].green = half_chan(col_a.green, col_b.green);
         data_in.palette[2].blue  = half_chan(col_a.blue, col_b.blue);
         data_in.palette[3]       = '0;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= data_in;
      end
   end

   assign blk_valid = valid_ff;
   assign blk_data  = data_ff;

endmodule

// ===== hw/rtl/bc1_queue.sv =====
// bc1_queue: short fifo of decoded palettes between front and back
// depends on bc1_pkg
`timescale 1ns / 1ps

module bc1_queue import bc1_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  block_type push_data,
   output logic      head_valid,
   input  logic      pop,
   output block_type head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   block_type        entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = count_ff != FULL_COUNT;
   assign head_valid = count_ff != '0;
   assign head_data  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("queue count above depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count missed a push");

endmodule

// ===== hw/rtl/bc1_back.sv =====
// bc1_back: walks the sixteen selectors of the head block, one texel per transfer
// depends on bc1_pkg; reads bc1_queue head
`timescale 1ns / 1ps

module bc1_back import bc1_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  block_type  head_data,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_texel_red,
   output logic [7:0] rsp_texel_green,
   output logic [7:0] rsp_texel_blue,
   output logic [3:0] rsp_texel_position,
   output logic       rsp_last_texel
);

   logic       valid_ff, valid_in;
   logic [3:0] cnt_ff, cnt_in;
   logic       load;
   logic [1:0] sel;
   rgb_type    color_ff;
   logic [3:0] pos_ff;
   logic       last_ff;

   assign load = head_valid && (!valid_ff || rsp_ready);
   assign sel  = head_data.selectors[{cnt_ff, 1'b0} +: 2];
   assign pop  = load && (cnt_ff == LAST_TEXEL_POS);

   always_comb begin
      valid_in = valid_ff;
      cnt_in   = cnt_ff;
      if (load) begin
         valid_in = 1'b1;
         cnt_in   = cnt_ff + 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         color_ff <= head_data.palette[sel];
         pos_ff   <= cnt_ff;
         last_ff  <= cnt_ff == LAST_TEXEL_POS;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_texel_red      = color_ff.red;
   assign rsp_texel_green    = color_ff.green;
   assign rsp_texel_blue     = color_ff.blue;
   assign rsp_texel_position = pos_ff;
   assign rsp_last_texel     = last_ff;

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_texel == (rsp_texel_position == LAST_TEXEL_POS)))
      else $error("last flag does not match position");

   a_pos_order: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_texel_position == $past(cnt_ff))
      else $error("texel position out of order");

   a_wrap_pop: assert property (@(posedge clock) disable iff (reset)
      pop |=> cnt_ff == '0)
      else $error("texel counter did not wrap at block end");

endmodule

// ===== hw/rtl/bc1_block_decoder.sv =====
// bc1_block_decoder: top level of the bc1 (dxt1) 4x4 block decoder
// depends on bc1_pkg, bc1_front, bc1_queue, bc1_back
//
//  channel  dir  handshake            payload
//  req      in   req_valid/req_ready  endpoint_a, endpoint_b, selector_bits
//  rsp      out  rsp_valid/rsp_ready  texel rgb, texel_position, last_texel
//
// one block yields sixteen texels, one per cycle from the output register
// while rsp_ready stays high and the queue holds a block
// the first texel passes the front stage, then the queue, then the output
// register; the front and the queue keep taking blocks while texels drain,
// holding up to QUEUE_DEPTH + 1 blocks in all
// reset clears all control state; a stall on rsp holds the current texel
`timescale 1ns / 1ps

module bc1_block_decoder import bc1_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_endpoint_a,
   input  logic [15:0] req_endpoint_b,
   input  logic [31:0] req_selector_bits,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_texel_red,
   output logic [7:0]  rsp_texel_green,
   output logic [7:0]  rsp_texel_blue,
   output logic [3:0]  rsp_texel_position,
   output logic        rsp_last_texel
);

   logic      blk_valid, blk_ready;
   block_type blk_data;
   logic      head_valid, pop;
   block_type head_data;

   bc1_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_endpoint_a    (req_endpoint_a),
      .req_endpoint_b    (req_endpoint_b),
      .req_selector_bits (req_selector_bits),
      .blk_valid         (blk_valid),
      .blk_ready         (blk_ready),
      .blk_data          (blk_data)
   );

   bc1_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (blk_valid),
      .push_ready (blk_ready),
      .push_data  (blk_data),
      .head_valid (head_valid),
      .pop        (pop),
      .head_data  (head_data)
   );

   bc1_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head_data          (head_data),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_texel_red      (rsp_texel_red),
      .rsp_texel_green    (rsp_texel_green),
      .rsp_texel_blue     (rsp_texel_blue),
      .rsp_texel_position (rsp_texel_position),
      .rsp_last_texel     (rsp_last_texel)
   );

endmodule
